// File: hw/rtl/fwdo_pkg.sv
// Shared types, constants and the arctangent table of the odometry block.
// Used by the arithmetic units, the register port and the top level.
// No dependencies.
package fwdo_pkg;

   localparam int CORDIC_STEPS_DEF = 24;
   localparam int FRAC_BITS_DEF = 16;

   // Shared shift-add multiplier: multiplicand, multiplier and product widths.
   localparam int MUL_A_W = 35;
   localparam int MUL_B_W = 56;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Shared restoring divider: dividend, divisor and quotient widths.
   localparam int DIV_N_W = 84;
   localparam int DIV_D_W = 63;
   localparam int DIV_Q_W = 51;

   localparam int CSR_AW = 3;
   localparam logic REG_RADIUS = 1'b0;
   localparam logic REG_SEPARATION = 1'b1;

   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [28:0] INV_4PI_Q32 = 29'd341782638;
   localparam logic [29:0] NS_PER_S = 30'd1000000000;
   localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

   typedef struct packed {
      logic start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_cmd_type;

   typedef struct packed {
      logic start;
      logic [DIV_N_W-1:0] num;
      logic [DIV_D_W-1:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic done;
      logic ovf;
      logic [DIV_Q_W-1:0] quot;
   } div_rsp_type;

   function automatic logic [29:0] atan_lut(input logic [4:0] idx);
      logic [29:0] r;
      case (idx)
         5'd0: r = 30'd536870912;
         5'd1: r = 30'd316933406;
         5'd2: r = 30'd167458907;
         5'd3: r = 30'd85004756;
         5'd4: r = 30'd42667331;
         5'd5: r = 30'd21354465;
         5'd6: r = 30'd10680350;
         5'd7: r = 30'd5340245;
         5'd8: r = 30'd2670163;
         5'd9: r = 30'd1335087;
         5'd10: r = 30'd667544;
         5'd11: r = 30'd333772;
         5'd12: r = 30'd166886;
         5'd13: r = 30'd83443;
         5'd14: r = 30'd41722;
         5'd15: r = 30'd20861;
         5'd16: r = 30'd10430;
         5'd17: r = 30'd5215;
         5'd18: r = 30'd2608;
         5'd19: r = 30'd1304;
         5'd20: r = 30'd652;
         5'd21: r = 30'd326;
         5'd22: r = 30'd163;
         5'd23: r = 30'd81;
         5'd24: r = 30'd41;
         5'd25: r = 30'd20;
         5'd26: r = 30'd10;
         5'd27: r = 30'd5;
         5'd28: r = 30'd3;
         5'd29: r = 30'd1;
         5'd30: r = 30'd1;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

endpackage

// File: hw/rtl/fwdo_ifs.sv
// Valid/ready channel interfaces for wheel sample words and pose words.
// Depends on nothing but the signal widths of the odometry block.
interface fwdo_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] pos_front_left;
   logic signed [31:0] pos_front_right;
   logic signed [31:0] pos_rear_left;
   logic signed [31:0] pos_rear_right;
   logic [62:0] stamp_ns;
   modport source(output valid, pos_front_left, pos_front_right, pos_rear_left,
                  pos_rear_right, stamp_ns, input ready);
   modport sink(input valid, pos_front_left, pos_front_right, pos_rear_left,
                pos_rear_right, stamp_ns, output ready);
endinterface

interface fwdo_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic [31:0] heading_angle;
   logic signed [31:0] quat_z;
   logic signed [31:0] quat_w;
   logic signed [31:0] linear_speed;
   logic signed [31:0] turn_rate;
   logic dt_zero;
   modport source(output valid, pos_x, pos_y, heading_angle, quat_z, quat_w,
                  linear_speed, turn_rate, dt_zero, input ready);
   modport sink(input valid, pos_x, pos_y, heading_angle, quat_z, quat_w,
                linear_speed, turn_rate, dt_zero, output ready);
endinterface

// File: hw/rtl/fwdo_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on fwdo_pkg for widths and the command struct.
module fwdo_mul (
   input  logic clock,
   input  logic reset,
   input  fwdo_pkg::mul_cmd_type cmd,
   output logic done,
   output logic [fwdo_pkg::MUL_P_W-1:0] prod
);
   localparam int AW = fwdo_pkg::MUL_A_W;
   localparam int BW = fwdo_pkg::MUL_B_W;
   localparam int PW = fwdo_pkg::MUL_P_W;
   localparam int CW = $clog2(BW);

   logic [PW-1:0] prod_ff, prod_in;
   logic [AW-1:0] a_ff, a_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [AW:0] sum;

   always_comb begin
      prod_in = prod_ff;
      a_in = a_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      // The multiplier sits in the low half and leaves one bit per cycle.
      sum = {1'b0, prod_ff[PW-1:BW]} + (prod_ff[0] ? {1'b0, a_ff} : '0);
      if (cmd.start) begin
         prod_in = {{AW{1'b0}}, cmd.b};
         a_in = cmd.a;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = {sum, prod_ff[BW-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(BW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      prod_ff <= prod_in;
      a_ff <= a_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;
endmodule

// File: hw/rtl/fwdo_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, with a sticky
// overflow flag for quotients wider than the kept field. Depends on fwdo_pkg.
module fwdo_div (
   input  logic clock,
   input  logic reset,
   input  fwdo_pkg::div_cmd_type cmd,
   output fwdo_pkg::div_rsp_type rsp
);
   localparam int NW = fwdo_pkg::DIV_N_W;
   localparam int DW = fwdo_pkg::DIV_D_W;
   localparam int QW = fwdo_pkg::DIV_Q_W;
   localparam int CW = $clog2(NW);

   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [QW-1:0] q_ff, q_in;
   logic ovf_ff, ovf_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [DW:0] shifted;
   logic [DW:0] diff;
   logic ge;

   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      ovf_in = ovf_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, num_ff[NW-1]};
      diff = shifted - {1'b0, den_ff};
      ge = (shifted >= {1'b0, den_ff});
      if (cmd.start) begin
         num_in = cmd.num;
         den_in = cmd.den;
         rem_in = '0;
         q_in = '0;
         ovf_in = 1'b0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NW-2:0], 1'b0};
         rem_in = ge ? diff[DW-1:0] : shifted[DW-1:0];
         q_in = {q_ff[QW-2:0], ge};
         ovf_in = ovf_ff | q_ff[QW-1];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      ovf_ff <= ovf_in;
   end

   assign rsp.done = done_ff;
   assign rsp.ovf = ovf_ff;
   assign rsp.quot = q_ff;
endmodule

// File: hw/rtl/fwdo_cordic.sv
// Iterative rotation CORDIC, one micro-rotation per cycle, giving clamped
// Q2.30 cosine and sine of a 32 bit binary angle. Depends on fwdo_pkg.
module fwdo_cordic #(
   parameter int STEPS = fwdo_pkg::CORDIC_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [31:0] ang,
   output logic done,
   output logic signed [31:0] cos_q,
   output logic signed [31:0] sin_q
);
   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [4:0] i_ff, i_in;
   logic flip_ff, flip_in;
   logic busy_ff, busy_in;
   logic fin_ff, fin_in;
   logic done_ff, done_in;
   logic signed [31:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [33:0] dx, dy, at;
   logic [31:0] rel;
   logic [31:0] ang_mapped;
   logic signed [31:0] xc, yc;

   function automatic logic signed [31:0] clamp(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'(fwdo_pkg::ONE_Q30)) r = fwdo_pkg::ONE_Q30;
      else if (v < -34'(fwdo_pkg::ONE_Q30)) r = -fwdo_pkg::ONE_Q30;
      else r = v[31:0];
      return r;
   endfunction

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      i_in = i_ff;
      flip_in = flip_ff;
      busy_in = busy_ff;
      fin_in = 1'b0;
      done_in = 1'b0;
      cos_in = cos_ff;
      sin_in = sin_ff;
      dx = y_ff >>> i_ff;
      dy = x_ff >>> i_ff;
      at = $signed({4'b0000, fwdo_pkg::atan_lut(i_ff)});
      // Angles in the left half plane are turned by half a turn first.
      rel = ang - 32'h4000_0000;
      ang_mapped = rel[31] ? ang : ang + 32'h8000_0000;
      xc = clamp(x_ff);
      yc = clamp(y_ff);
      if (start) begin
         x_in = fwdo_pkg::CORDIC_GAIN;
         y_in = '0;
         z_in = 34'($signed(ang_mapped));
         i_in = '0;
         flip_in = !rel[31];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == 5'(STEPS - 1)) begin
            busy_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         cos_in = flip_ff ? -xc : xc;
         sin_in = flip_ff ? -yc : yc;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff <= 1'b0;
         done_ff <= 1'b0;
         i_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff <= fin_in;
         done_ff <= done_in;
         i_ff <= i_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      flip_ff <= flip_in;
      cos_ff <= cos_in;
      sin_ff <= sin_in;
   end

   assign done = done_ff;
   assign cos_q = cos_ff;
   assign sin_q = sin_ff;
endmodule

// File: hw/rtl/fwdo_csr.sv
// APB-style register port holding wheel radius and wheel separation.
// Depends on fwdo_pkg for address width and register indexes.
module fwdo_csr #(
   parameter logic [15:0] RADIUS_RST = 16'd2163,
   parameter logic [17:0] SEP_RST = 18'd15663
) (
   input  logic clock,
   input  logic reset,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [fwdo_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready,
   output logic [15:0] radius,
   output logic [17:0] separation
);
   logic [15:0] radius_ff, radius_in;
   logic [17:0] sep_ff, sep_in;
   logic wr;

   always_comb begin
      wr = psel && penable && pwrite;
      radius_in = radius_ff;
      sep_in = sep_ff;
      if (wr) begin
         case (paddr[2])
            fwdo_pkg::REG_RADIUS: radius_in = pwdata[15:0];
            fwdo_pkg::REG_SEPARATION: sep_in = pwdata[17:0];
            default: ;
         endcase
      end
      case (paddr[2])
         fwdo_pkg::REG_RADIUS: prdata = 32'(radius_ff);
         fwdo_pkg::REG_SEPARATION: prdata = 32'(sep_ff);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RST;
         sep_ff <= SEP_RST;
      end else begin
         radius_ff <= radius_in;
         sep_ff <= sep_in;
      end
   end

   assign pready = 1'b1;
   assign radius = radius_ff;
   assign separation = sep_ff;
endmodule

// File: hw/rtl/four_wheel_diff_drive_odometry.sv
// Top level of the four wheel differential drive odometry block: sequencer,
// state and result registers. Depends on fwdo_pkg, fwdo_ifs, fwdo_mul,
// fwdo_div, fwdo_cordic and fwdo_csr.
//
//   channel | direction | handshake          | word
//   req     | in        | valid/ready        | four wheel angles, stamp_ns
//   rsp     | out       | valid/ready        | pose, quaternion, speeds, dt_zero
//   csr     | in        | psel/penable/pready| radius, track width
//
// Each word runs seven serial multiplies and three serial divides, which share
// one multiplier and one divider, plus two CORDIC runs.
// A word with a zero time delta skips the speed work.
// Reset is synchronous and clears the pose, heading, stored angles and stamp.
// A finished word waits in the output register while the next one is taken;
// a stalled rsp holds the sequencer only at its last step.
module four_wheel_diff_drive_odometry #(
   parameter int CORDIC_STEPS = fwdo_pkg::CORDIC_STEPS_DEF,
   parameter int FRAC_BITS = fwdo_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   fwdo_req_if.sink req,
   fwdo_rsp_if.source rsp,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [fwdo_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   localparam int PW = fwdo_pkg::MUL_P_W;
   localparam int NW = fwdo_pkg::DIV_N_W;
   localparam logic [63:0] RADIUS_FULL = ((64'd33 << FRAC_BITS) + 64'd500) / 64'd1000;
   localparam logic [63:0] SEP_FULL = ((64'd239 << FRAC_BITS) + 64'd500) / 64'd1000;
   localparam logic [15:0] RADIUS_RST = RADIUS_FULL[15:0];
   localparam logic [17:0] SEP_RST = SEP_FULL[17:0];

   typedef enum logic [13:0] {
      S_IDLE    = 14'b00000000000001,
      S_MUL_S   = 14'b00000000000010,
      S_MUL_D   = 14'b00000000000100,
      S_DIV_TH  = 14'b00000000001000,
      S_MUL_H   = 14'b00000000010000,
      S_COR_POS = 14'b00000000100000,
      S_MUL_X   = 14'b00000001000000,
      S_MUL_Y   = 14'b00000010000000,
      S_COR_Q   = 14'b00000100000000,
      S_MUL_LIN = 14'b00001000000000,
      S_DIV_LIN = 14'b00010000000000,
      S_MUL_ANG = 14'b00100000000000,
      S_DIV_ANG = 14'b01000000000000,
      S_OUT     = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic wait_ff, wait_in;

   logic [31:0] prev_ff [4];
   logic [31:0] prev_in [4];
   logic [62:0] stamp_ff, stamp_in;
   logic signed [31:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [31:0] heading_ff, heading_in;

   logic [34:0] smag_ff, smag_in, dmag_ff, dmag_in;
   logic s_neg_ff, s_neg_in, d_neg_ff, d_neg_in;
   logic [62:0] md_ff, md_in;
   logic dt_neg_ff, dt_neg_in, zero_ff, zero_in;
   logic signed [55:0] ds_ff, ds_in, dth_ff, dth_in;
   logic [NW-1:0] num_ff, num_in;
   logic [62:0] den_ff, den_in;
   logic signed [31:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [31:0] lin_ff, lin_in, ang_ff, ang_in;

   logic out_valid_ff, out_valid_in;
   logic signed [31:0] o_x_ff, o_y_ff, o_qz_ff, o_qw_ff, o_lin_ff, o_ang_ff;
   logic [31:0] o_head_ff;
   logic o_zero_ff;
   logic out_load;

   fwdo_pkg::mul_cmd_type mul_cmd;
   fwdo_pkg::div_cmd_type div_cmd;
   fwdo_pkg::div_rsp_type div_rsp;
   logic mul_done;
   logic [PW-1:0] mul_prod;
   logic cor_start, cor_done;
   logic [31:0] cor_ang;
   logic signed [31:0] cor_cos, cor_sin;

   logic [15:0] radius;
   logic [17:0] separation, sep_eff;

   logic [31:0] pos_in [4];
   logic signed [32:0] dw [4];
   logic signed [34:0] s_cap, d_cap;
   logic [62:0] u_cap;
   logic [52:0] rnd, rmag;
   logic [55:0] mag56;
   logic [FRAC_BITS+31:0] hs;
   logic accept, unit_start;

   function automatic logic [55:0] abs56(input logic signed [55:0] v);
      return v[55] ? 56'(-v) : 56'(v);
   endfunction

   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

   function automatic logic signed [55:0] apply_sign(input logic neg, input logic [55:0] m);
      return neg ? -$signed(m) : $signed(m);
   endfunction

   // Rounded pose step ds*trig/2^30 with its cap, added with saturation.
   function automatic logic signed [31:0] pose_step(input logic signed [31:0] acc,
                                                    input logic [PW-1:0] p,
                                                    input logic neg);
      logic [71:0] t;
      logic [41:0] q;
      logic signed [42:0] qs, sum;
      logic signed [31:0] r;
      t = {1'b0, p[70:0]} + (72'd1 << 29);
      q = t[71:30];
      if (q > (42'd1 << 40)) q = 42'd1 << 40;
      qs = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
      sum = 43'(acc) + qs;
      if (sum > 43'sd2147483647) r = 32'sh7FFF_FFFF;
      else if (sum < -43'sd2147483648) r = 32'sh8000_0000;
      else r = sum[31:0];
      return r;
   endfunction

   // Saturating speed from the serial quotient.
   function automatic logic signed [31:0] rate_fin(input fwdo_pkg::div_rsp_type d,
                                                   input logic neg);
      logic [31:0] limit, m;
      limit = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      if (d.ovf || d.quot > fwdo_pkg::DIV_Q_W'(limit)) m = limit;
      else m = d.quot[31:0];
      return neg ? -$signed(m) : $signed(m);
   endfunction

   fwdo_csr #(.RADIUS_RST(RADIUS_RST), .SEP_RST(SEP_RST)) u_csr (
      .clock(clock), .reset(reset), .psel(csr_psel), .penable(csr_penable),
      .pwrite(csr_pwrite), .paddr(csr_paddr), .pwdata(csr_pwdata),
      .prdata(csr_prdata), .pready(csr_pready), .radius(radius),
      .separation(separation)
   );

   fwdo_mul u_mul (
      .clock(clock), .reset(reset), .cmd(mul_cmd), .done(mul_done), .prod(mul_prod)
   );

   fwdo_div u_div (.clock(clock), .reset(reset), .cmd(div_cmd), .rsp(div_rsp));

   fwdo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cor_start), .ang(cor_ang),
      .done(cor_done), .cos_q(cor_cos), .sin_q(cor_sin)
   );

   assign pos_in[0] = req.pos_front_left;
   assign pos_in[1] = req.pos_front_right;
   assign pos_in[2] = req.pos_rear_left;
   assign pos_in[3] = req.pos_rear_right;
   assign sep_eff = (separation == '0) ? 18'd1 : separation;
   assign req.ready = (state_ff == S_IDLE);
   assign accept = req.valid && req.ready;
   assign unit_start = !wait_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         dw[k] = $signed({pos_in[k][31], pos_in[k]}) - $signed({prev_ff[k][31], prev_ff[k]});
      end
      s_cap = 35'(dw[1]) + 35'(dw[3]) + 35'(dw[0]) + 35'(dw[2]);
      d_cap = (35'(dw[1]) + 35'(dw[3])) - (35'(dw[0]) + 35'(dw[2]));
      u_cap = req.stamp_ns - stamp_ff;

      mul_cmd.start = 1'b0;
      mul_cmd.a = '0;
      mul_cmd.b = '0;
      div_cmd.start = 1'b0;
      div_cmd.num = num_ff;
      div_cmd.den = den_ff;
      cor_start = 1'b0;
      cor_ang = heading_ff;
      case (state_ff)
         S_MUL_S: begin
            mul_cmd.start = unit_start;
            mul_cmd.a = smag_ff;
            mul_cmd.b = 56'(radius);
         end
         S_MUL_D: begin
            mul_cmd.start = unit_start;
            mul_cmd.a = dmag_ff;
            mul_cmd.b = 56'(radius);
         end
         S_MUL_H: begin
            mul_cmd.start = unit_start;
            mul_cmd.a = 35'(fwdo_pkg::INV_4PI_Q32);
            mul_cmd.b = 56'(dth_ff[FRAC_BITS+31:0]);
         end
         S_MUL_X: begin
            mul_cmd.start = unit_start;
            mul_cmd.a = 35'(abs32(cos_ff));
            mul_cmd.b = abs56(ds_ff);
         end
         S_MUL_Y: begin
            mul_cmd.start = unit_start;
            mul_cmd.a = 35'(abs32(sin_ff));
            mul_cmd.b = abs56(ds_ff);
         end
         S_MUL_LIN: begin
            mul_cmd.start = unit_start;
            mul_cmd.a = 35'(fwdo_pkg::NS_PER_S);
            mul_cmd.b = abs56(ds_ff);
         end
         S_MUL_ANG: begin
            mul_cmd.start = unit_start;
            mul_cmd.a = 35'(fwdo_pkg::NS_PER_S);
            mul_cmd.b = abs56(dth_ff);
         end
         S_DIV_TH, S_DIV_LIN, S_DIV_ANG: div_cmd.start = unit_start;
         S_COR_POS: begin
            cor_start = unit_start;
            cor_ang = {heading_ff[30:0], 1'b0};
         end
         S_COR_Q: cor_start = unit_start;
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      wait_in = wait_ff;
      prev_in = prev_ff;
      stamp_in = stamp_ff;
      acc_x_in = acc_x_ff;
      acc_y_in = acc_y_ff;
      heading_in = heading_ff;
      smag_in = smag_ff;
      dmag_in = dmag_ff;
      s_neg_in = s_neg_ff;
      d_neg_in = d_neg_ff;
      md_in = md_ff;
      dt_neg_in = dt_neg_ff;
      zero_in = zero_ff;
      ds_in = ds_ff;
      dth_in = dth_ff;
      num_in = num_ff;
      den_in = den_ff;
      cos_in = cos_ff;
      sin_in = sin_ff;
      lin_in = lin_ff;
      ang_in = ang_ff;
      out_load = 1'b0;
      rnd = mul_prod[52:0] + (53'd1 << (FRAC_BITS + 1));
      rmag = rnd >> (FRAC_BITS + 2);
      mag56 = 56'(rmag);
      hs = mul_prod[FRAC_BITS+31:0] + ((FRAC_BITS + 32)'(1) << (FRAC_BITS - 1));

      if (mul_cmd.start || div_cmd.start || cor_start) wait_in = 1'b1;
      if (mul_done || div_rsp.done || cor_done) wait_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               prev_in = pos_in;
               stamp_in = req.stamp_ns;
               s_neg_in = s_cap[34];
               smag_in = s_cap[34] ? 35'(-s_cap) : 35'(s_cap);
               d_neg_in = d_cap[34];
               dmag_in = d_cap[34] ? 35'(-d_cap) : 35'(d_cap);
               // The stamp difference is read as a signed 63 bit value.
               dt_neg_in = u_cap[62];
               md_in = u_cap[62] ? 63'(-u_cap) : u_cap;
               zero_in = (u_cap == '0);
               state_in = S_MUL_S;
            end
         end
         S_MUL_S: begin
            if (mul_done) begin
               ds_in = apply_sign(s_neg_ff, mag56);
               state_in = S_MUL_D;
            end
         end
         S_MUL_D: begin
            if (mul_done) begin
               num_in = NW'(mul_prod[51:0]) + NW'(sep_eff);
               den_in = 63'({sep_eff, 1'b0});
               state_in = S_DIV_TH;
            end
         end
         S_DIV_TH: begin
            if (div_rsp.done) begin
               dth_in = apply_sign(d_neg_ff, 56'(div_rsp.quot));
               state_in = S_MUL_H;
            end
         end
         S_MUL_H: begin
            if (mul_done) begin
               heading_in = heading_ff + hs[FRAC_BITS+31:FRAC_BITS];
               state_in = S_COR_POS;
            end
         end
         S_COR_POS: begin
            if (cor_done) begin
               cos_in = cor_cos;
               sin_in = cor_sin;
               state_in = S_MUL_X;
            end
         end
         S_MUL_X: begin
            if (mul_done) begin
               acc_x_in = pose_step(acc_x_ff, mul_prod, ds_ff[55] ^ cos_ff[31]);
               state_in = S_MUL_Y;
            end
         end
         S_MUL_Y: begin
            if (mul_done) begin
               acc_y_in = pose_step(acc_y_ff, mul_prod, ds_ff[55] ^ sin_ff[31]);
               state_in = S_COR_Q;
            end
         end
         S_COR_Q: begin
            if (cor_done) begin
               if (zero_ff) begin
                  lin_in = '0;
                  ang_in = '0;
                  state_in = S_OUT;
               end else begin
                  state_in = S_MUL_LIN;
               end
            end
         end
         S_MUL_LIN: begin
            if (mul_done) begin
               num_in = mul_prod[NW-1:0] + NW'(md_ff >> 1);
               den_in = md_ff;
               state_in = S_DIV_LIN;
            end
         end
         S_DIV_LIN: begin
            if (div_rsp.done) begin
               lin_in = rate_fin(div_rsp, ds_ff[55] ^ dt_neg_ff);
               state_in = S_MUL_ANG;
            end
         end
         S_MUL_ANG: begin
            if (mul_done) begin
               num_in = mul_prod[NW-1:0] + NW'(md_ff >> 1);
               state_in = S_DIV_ANG;
            end
         end
         S_DIV_ANG: begin
            if (div_rsp.done) begin
               ang_in = rate_fin(div_rsp, dth_ff[55] ^ dt_neg_ff);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!out_valid_ff || rsp.ready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      out_valid_in = out_valid_ff;
      if (rsp.ready) out_valid_in = 1'b0;
      if (out_load) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wait_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < 4; k++) prev_ff[k] <= '0;
         stamp_ff <= '0;
         acc_x_ff <= '0;
         acc_y_ff <= '0;
         heading_ff <= '0;
      end else begin
         state_ff <= state_in;
         wait_ff <= wait_in;
         out_valid_ff <= out_valid_in;
         prev_ff <= prev_in;
         stamp_ff <= stamp_in;
         acc_x_ff <= acc_x_in;
         acc_y_ff <= acc_y_in;
         heading_ff <= heading_in;
      end
      smag_ff <= smag_in;
      dmag_ff <= dmag_in;
      s_neg_ff <= s_neg_in;
      d_neg_ff <= d_neg_in;
      md_ff <= md_in;
      dt_neg_ff <= dt_neg_in;
      zero_ff <= zero_in;
      ds_ff <= ds_in;
      dth_ff <= dth_in;
      num_ff <= num_in;
      den_ff <= den_in;
      cos_ff <= cos_in;
      sin_ff <= sin_in;
      lin_ff <= lin_in;
      ang_ff <= ang_in;
      if (out_load) begin
         o_x_ff <= acc_x_ff;
         o_y_ff <= acc_y_ff;
         o_head_ff <= heading_ff;
         o_qz_ff <= cor_sin;
         o_qw_ff <= cor_cos;
         o_lin_ff <= lin_ff;
         o_ang_ff <= ang_ff;
         o_zero_ff <= zero_ff;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.pos_x = o_x_ff;
   assign rsp.pos_y = o_y_ff;
   assign rsp.heading_angle = o_head_ff;
   assign rsp.quat_z = o_qz_ff;
   assign rsp.quat_w = o_qw_ff;
   assign rsp.linear_speed = o_lin_ff;
   assign rsp.turn_rate = o_ang_ff;
   assign rsp.dt_zero = o_zero_ff;

   // A word with a zero time delta reports zero speeds.
   a_zero_speed: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.dt_zero |-> rsp.linear_speed == 0 && rsp.turn_rate == 0)
      else $error("speeds not zero on a zero time delta");

   // The quaternion terms stay within one in Q2.30.
   a_quat_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.quat_z <= fwdo_pkg::ONE_Q30 && rsp.quat_z >= -fwdo_pkg::ONE_Q30
                 && rsp.quat_w <= fwdo_pkg::ONE_Q30 && rsp.quat_w >= -fwdo_pkg::ONE_Q30)
      else $error("quaternion term out of range");

   // Once a word is taken no other is taken until its work is done.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("input taken while a word is in flight");

   // Only one arithmetic unit is launched at a time.
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({mul_cmd.start, div_cmd.start, cor_start}))
      else $error("two arithmetic units launched together");
endmodule

// File: dv/tb_top.sv
// Self-checking testbench of the four wheel differential drive odometry block.
// Drives wheel sample words, predicts every pose word in its own fixed-point model
// and compares; depends on fwdo_pkg, fwdo_ifs and the block's RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEMS = 1050;
   localparam longint CYCLE_LIMIT = 8000000;
   localparam int SETTLE = 1000;
   localparam int ADDR_W = fwdo_pkg::CSR_AW;
   localparam logic [ADDR_W-1:0] ADDR_RADIUS = ADDR_W'(4 * fwdo_pkg::REG_RADIUS);
   localparam logic [ADDR_W-1:0] ADDR_SEPARATION = ADDR_W'(4 * fwdo_pkg::REG_SEPARATION);
   localparam longint unsigned MASK63 = 64'h7fff_ffff_ffff_ffff;

   typedef struct packed {
      logic [31:0] fl, fr, rl, rr;
      logic [62:0] stamp;
   } sample_type;

   typedef struct packed {
      logic [31:0] x, y, heading, qz, qw, lin, ang;
      logic dtz;
   } pose_type;

   // One directed row; when typed is set, the listed values replace the
   // computed ones for everything except the quaternion.
   typedef struct {
      sample_type s;
      bit typed;
      pose_type p;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   fwdo_req_if req ();
   fwdo_rsp_if rsp ();

   four_wheel_diff_drive_odometry dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Predictor state and configuration.
   logic [31:0] last_angle [4];
   logic [62:0] last_stamp;
   longint odo_x, odo_y;
   logic [31:0] odo_heading;
   logic [15:0] radius;
   logic [17:0] separation;

   pose_type pending_poses [$];
   int errors = 0, words_seen = 0, zero_dt_seen = 0;
   longint cycles = 0;
   bit stim_done = 1'b0;

   const longint unsigned atan_steps [32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10680350,
      5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
      10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};

   function automatic longint unsigned mag(longint v);
      return v < 0 ? 64'd0 - longint'(v) : v;
   endfunction

   function automatic longint with_sign(bit neg, longint unsigned m);
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic void rotate(input logic [31:0] ang, output longint c,
                                  output longint s);
      logic [31:0] shifted;
      bit flip;
      longint x, y, z, dx, dy;
      shifted = ang - 32'h4000_0000;
      flip = shifted < 32'h8000_0000;
      if (flip) ang = ang + 32'h8000_0000;
      x = 652032874;
      y = 0;
      z = longint'(signed'(ang));
      for (int i = 0; i < fwdo_pkg::CORDIC_STEPS_DEF; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_steps[i]);
         end else begin
            x += dx; y -= dy; z += longint'(atan_steps[i]);
         end
      end
      if (x > 64'sd1073741824) x = 64'sd1073741824;
      if (x < -64'sd1073741824) x = -64'sd1073741824;
      if (y > 64'sd1073741824) y = 64'sd1073741824;
      if (y < -64'sd1073741824) y = -64'sd1073741824;
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint advance_axis(longint acc, longint ds, longint trig);
      logic [127:0] p;
      logic [127:0] q;
      p = 128'(mag(ds)) * 128'(mag(trig) & 64'hffff_ffff) + (128'd1 << 29);
      q = p >> 30;
      if (q > (128'd1 << 40)) q = 128'd1 << 40;
      return clamp32(acc + with_sign((ds < 0) != (trig < 0), q[63:0]));
   endfunction

   // Value times 1e9 over the time delta, rounded, saturated to 32 bits.
   function automatic longint per_second(longint v, longint dt);
      logic [127:0] n, q;
      longint unsigned md, lim;
      bit neg;
      md = mag(dt);
      neg = (v < 0) != (dt < 0);
      lim = neg ? 64'd2147483648 : 64'd2147483647;
      n = 128'(mag(v)) * 128'd1000000000 + 128'(md >> 1);
      q = n / 128'(md);
      if (q > 128'(lim)) q = 128'(lim);
      return with_sign(neg, q[63:0]);
   endfunction

   function automatic void odometry_reset();
      foreach (last_angle[k]) last_angle[k] = '0;
      last_stamp = '0;
      odo_x = 0;
      odo_y = 0;
      odo_heading = '0;
      radius = 16'd2163;
      separation = 18'd15663;
   endfunction

   function automatic pose_type odometry_step(sample_type s);
      logic [31:0] now [4];
      longint d [4];
      longint sum_l, sum_r, dt, ds, dth, c, sn, qz, qw;
      longint unsigned u, sep, upd;
      pose_type p;
      now = '{s.fl, s.fr, s.rl, s.rr};
      for (int k = 0; k < 4; k++) begin
         d[k] = longint'(signed'(now[k])) - longint'(signed'(last_angle[k]));
         last_angle[k] = now[k];
      end
      sum_l = d[0] + d[2];
      sum_r = d[1] + d[3];
      u = (64'(s.stamp) - 64'(last_stamp)) & MASK63;
      // A delta with bit 62 set is read as time running backwards.
      if (u[62]) dt = -longint'(((64'd1 << 63) - u) & MASK63);
      else dt = longint'(u);
      last_stamp = s.stamp;
      sep = separation == 0 ? 64'd1 : 64'(separation);
      ds = longint'(radius) * (sum_r + sum_l);
      ds = with_sign(ds < 0, (mag(ds) + (64'd1 << 17)) >> 18);
      dth = longint'(radius) * (sum_r - sum_l);
      dth = with_sign(dth < 0, (mag(dth) + sep) / (2 * sep));
      upd = longint'(dth) * 64'd341782638 + 64'd32768;
      odo_heading = odo_heading + upd[47:16];
      rotate({odo_heading[30:0], 1'b0}, c, sn);
      odo_x = advance_axis(odo_x, ds, c);
      odo_y = advance_axis(odo_y, ds, sn);
      rotate(odo_heading, qw, qz);
      p.x = odo_x[31:0];
      p.y = odo_y[31:0];
      p.heading = odo_heading;
      p.qz = qz[31:0];
      p.qw = qw[31:0];
      p.dtz = dt == 0;
      p.lin = p.dtz ? '0 : 32'(per_second(ds, dt));
      p.ang = p.dtz ? '0 : 32'(per_second(dth, dt));
      return p;
   endfunction

   task automatic csr_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_RADIUS) radius = data[15:0];
      else separation = data[17:0];
   endtask

   task automatic set_geometry(logic [31:0] r, logic [31:0] sep);
      req.valid <= 1'b0;
      wait (pending_poses.size() == 0);
      repeat (SETTLE) @(posedge clock);
      csr_write(ADDR_RADIUS, r);
      csr_write(ADDR_SEPARATION, sep);
   endtask

   // Sender: bursts of back-to-back words separated by random gaps.
   int burst_left = 0;

   task automatic send_sample(sample_type s, bit typed, pose_type typed_pose);
      pose_type p;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 40));
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req.valid <= 1'b1;
      {req.pos_front_left, req.pos_front_right, req.pos_rear_left, req.pos_rear_right,
       req.stamp_ns} <= s;
      do @(posedge clock); while (!req.ready);
      burst_left--;
      p = odometry_step(s);
      if (typed) begin
         p.x = typed_pose.x; p.y = typed_pose.y; p.heading = typed_pose.heading;
         p.lin = typed_pose.lin; p.ang = typed_pose.ang; p.dtz = typed_pose.dtz;
      end
      pending_poses.push_back(p);
   endtask

   // Random words: mostly smooth motion with realistic sample periods, the
   // rest raw noise, repeated stamps and backward jumps in time.
   sample_type track;

   task automatic random_phase(int count);
      sample_type s;
      int kind;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(0, 99);
         s = track;
         if (kind < 70) begin
            s.fl = track.fl + $urandom_range(0, 262144) - 131072;
            s.rl = track.rl + $urandom_range(0, 262144) - 131072;
            s.fr = track.fr + $urandom_range(0, 262144) - 131072;
            s.rr = track.rr + $urandom_range(0, 262144) - 131072;
            s.stamp = track.stamp + 63'($urandom_range(1000000, 100000000));
         end else if (kind < 85) begin
            s.fl = $urandom; s.fr = $urandom; s.rl = $urandom; s.rr = $urandom;
            s.stamp = 63'({$urandom, $urandom});
         end else if (kind < 92) begin
            s.fl = $urandom; s.fr = $urandom;
         end else if (kind < 96) begin
            s.stamp = track.stamp - 63'($urandom_range(1, 100000000));
         end else begin
            s.fr = track.fr + 32'($urandom_range(0, 65535));
         end
         send_sample(s, 1'b0, '0);
         track = s;
      end
   endtask

   row_type rows [$];

   function automatic row_type mk(logic [31:0] fl, logic [31:0] fr, logic [31:0] rl,
                                  logic [31:0] rr, logic [62:0] st);
      row_type r;
      r.s = '{fl, fr, rl, rr, st};
      r.typed = 1'b0;
      r.p = '0;
      return r;
   endfunction

   initial begin
      row_type r;
      req.valid <= 1'b0;
      {req.pos_front_left, req.pos_front_right, req.pos_rear_left, req.pos_rear_right,
       req.stamp_ns} <= '0;
      odometry_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // First word after reset with nothing moved and no time passed.
      r = mk('0, '0, '0, '0, '0);
      r.typed = 1'b1;
      r.p.dtz = 1'b1;
      rows.push_back(r);
      rows.push_back(mk(32'd65536, 32'd65536, 32'd65536, 32'd65536, 63'd10000000));
      rows.push_back(mk(32'd65536, 32'd65536, 32'd65536, 32'd65536, 63'd10000000));
      rows.push_back(mk('0, 32'd131072, '0, 32'd131072, 63'd20000000));
      rows.push_back(mk(32'd200000, '0, 32'd200000, '0, 63'd30000000));
      rows.push_back(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        63'd30000001));
      rows.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        63'd30000002));
      rows.push_back(mk(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                        63'h7fff_ffff_ffff_ffff));
      rows.push_back(mk(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, '0));
      rows.push_back(mk('0, '0, '0, '0, 63'd5));
      rows.push_back(mk(32'd1000, 32'd1000, 32'd1000, 32'd1000, 63'd1));
      rows.push_back(mk(32'hffff_0000, 32'd65536, 32'hffff_0000, 32'd65536,
                        63'h4000_0000_0000_0001));
      rows.push_back(mk(32'hffff_0000, 32'd65536, 32'hffff_0000, 32'd65536, 63'd1));
      foreach (rows[i]) send_sample(rows[i].s, rows[i].typed, rows[i].p);
      track = rows[rows.size() - 1].s;

      // Smallest geometry, the mixed and largest corners, then random, then reset values.
      set_geometry(32'd1, 32'd1);
      random_phase(150);
      set_geometry(32'd65535, 32'd1);
      random_phase(150);
      set_geometry(32'd65535, 32'd262143);
      random_phase(150);
      set_geometry(32'd1, 32'd262143);
      random_phase(100);
      for (int ph = 0; ph < 3; ph++) begin
         set_geometry($urandom_range(1, 65535), $urandom_range(1, 262143));
         random_phase(100);
      end
      set_geometry(32'd2163, 32'd15663);
      random_phase(187);
      req.valid <= 1'b0;
      wait (pending_poses.size() == 0);
      repeat (SETTLE) @(posedge clock);
      stim_done = 1'b1;
   end

   // Receiver stall pattern, picked at random: always ready, coin flip, rarely ready or a periodic window.
   logic [2:0] stall_mode = '0;

   always @(posedge clock) begin
      if (cycles % 3000 == 0) stall_mode <= 3'($urandom_range(0, 4));
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         case (stall_mode)
            3'd0, 3'd1: rsp.ready <= 1'b1;
            3'd2: rsp.ready <= 1'($urandom_range(0, 1));
            3'd3: rsp.ready <= $urandom_range(0, 7) == 0;
            default: rsp.ready <= (cycles % 64) > 40;
         endcase
      end
   end

   always @(posedge clock) begin
      pose_type got, want;
      cycles <= cycles + 1;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.pos_x, rsp.pos_y, rsp.heading_angle, rsp.quat_z, rsp.quat_w,
                 rsp.linear_speed, rsp.turn_rate, rsp.dt_zero};
         words_seen++;
         if (got.dtz) zero_dt_seen++;
         if (pending_poses.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected pose word %0d: %h", words_seen, got);
         end else begin
            want = pending_poses.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display({"pose word %0d mismatch\n  exp x=%h y=%h hd=%h qz=%h qw=%h",
                            " lin=%h ang=%h dtz=%b\n  got x=%h y=%h hd=%h qz=%h qw=%h",
                            " lin=%h ang=%h dtz=%b"}, words_seen,
                           want.x, want.y, want.heading, want.qz, want.qw, want.lin,
                           want.ang, want.dtz, got.x, got.y, got.heading, got.qz,
                           got.qw, got.lin, got.ang, got.dtz);
            end
         end
      end
   end

   initial begin
      wait (stim_done || cycles >= CYCLE_LIMIT);
      if (!stim_done) begin
         $display("timeout with %0d pose words outstanding", pending_poses.size());
         $display("tb_top: done, errors");
      end else begin
         $display("covered %0d pose words (%0d with zero time delta) over 8 geometry settings",
                  words_seen, zero_dt_seen);
         $display("mismatching words: %0d", errors);
         if (errors == 0) $display("tb_top: done, clean");
         else $display("tb_top: done, errors");
      end
      $finish;
   end
endmodule
